### rtl/core/assert_macros.svh
// Assertion macros shared by the checker files of the line stepper.
// Each macro takes a label, the clock, the active-low reset and two expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BLS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bls_checker: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define BLS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bls_checker: next-cycle property failed");

`endif

### rtl/core/bls_pkg.sv
// Package of the line stepper: opcodes, line styles, pattern constants and helpers.
// It depends on nothing; every other file of the block but assert_macros.svh uses it.
`timescale 1ns / 1ps
`default_nettype none

package bls_pkg;

    localparam int COORD_BITS_DEF = 11;

    localparam int PATTERN_LEN = 8;
    localparam int DASH_ON     = 5;
    localparam int DOT_PERIOD  = 2;
    localparam int PHASE_BITS  = $clog2(PATTERN_LEN);

    localparam int SIGN_X_MOVE = 0;
    localparam int SIGN_X_NEG  = 1;
    localparam int SIGN_Y_MOVE = 2;
    localparam int SIGN_Y_NEG  = 3;
    localparam int SIGN_BITS   = 4;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        STYLE_SIMPLE = 2'd0,
        STYLE_DOTTED = 2'd1,
        STYLE_DASHED = 2'd2,
        STYLE_SOLID  = 2'd3
    } style_t;

    typedef logic [PHASE_BITS-1:0] phase_t;

    typedef struct packed {
        logic take;
        logic emit;
    } eng_ctrl_t;

    function automatic logic style_draws(style_t style, phase_t phase);
        logic draws;
        case (style)
            STYLE_DOTTED:
            begin
                draws = ((phase & phase_t'(DOT_PERIOD - 1)) == '0);
            end
            STYLE_DASHED:
            begin
                draws = (phase < phase_t'(DASH_ON));
            end
            default:
            begin
                draws = 1'b1;
            end
        endcase
        return draws;
    endfunction

endpackage

`default_nettype wire

### rtl/core/bls_if.sv
// Channel interfaces of the line stepper: command, pixel and style configuration.
// They depend on bls_pkg for the opcode and style types.
`timescale 1ns / 1ps
`default_nettype none

interface bls_cmd_if #(
    parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    bls_pkg::opcode_t      opcode;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;

    modport source (output valid, opcode, start_x, start_y, end_x, end_y, input ready);
    modport sink (input valid, opcode, start_x, start_y, end_x, end_y, output ready);
endinterface

interface bls_pixel_if #(
    parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  visible;
    logic                  last_pixel;

    modport source (output valid, pixel_x, pixel_y, visible, last_pixel, input ready);
    modport sink (input valid, pixel_x, pixel_y, visible, last_pixel, output ready);
endinterface

interface bls_cfg_if;
    logic              valid;
    logic              ready;
    bls_pkg::style_t   line_style;

    modport source (output valid, line_style, input ready);
    modport sink (input valid, line_style, output ready);
endinterface

`default_nettype wire

### rtl/core/bls_in_stage.sv
// Input register of the line stepper: holds one command until the engine takes it.
// It depends on bls_pkg for the opcode type and the engine control struct.
`timescale 1ns / 1ps
`default_nettype none

module bls_in_stage #(
    parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cmd_valid,
    output logic                       cmd_ready,
    input  wire bls_pkg::opcode_t      cmd_opcode,
    input  wire logic [COORD_BITS-1:0] cmd_start_x,
    input  wire logic [COORD_BITS-1:0] cmd_start_y,
    input  wire logic [COORD_BITS-1:0] cmd_end_x,
    input  wire logic [COORD_BITS-1:0] cmd_end_y,
    input  wire bls_pkg::eng_ctrl_t    ctrl,
    output logic                       item_valid,
    output bls_pkg::opcode_t           item_opcode,
    output logic [COORD_BITS-1:0]      item_start_x,
    output logic [COORD_BITS-1:0]      item_start_y,
    output logic [COORD_BITS-1:0]      item_end_x,
    output logic [COORD_BITS-1:0]      item_end_y
);

    logic                  valid_reg;
    bls_pkg::opcode_t      opcode_reg;
    logic [COORD_BITS-1:0] start_x_reg;
    logic [COORD_BITS-1:0] start_y_reg;
    logic [COORD_BITS-1:0] end_x_reg;
    logic [COORD_BITS-1:0] end_y_reg;

    assign cmd_ready = !valid_reg || ctrl.take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd_ready)
        begin
            valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            opcode_reg  <= cmd_opcode;
            start_x_reg <= cmd_start_x;
            start_y_reg <= cmd_start_y;
            end_x_reg   <= cmd_end_x;
            end_y_reg   <= cmd_end_y;
        end
    end

    assign item_valid   = valid_reg;
    assign item_opcode  = opcode_reg;
    assign item_start_x = start_x_reg;
    assign item_start_y = start_y_reg;
    assign item_end_x   = end_x_reg;
    assign item_end_y   = end_y_reg;

endmodule

`default_nettype wire

### rtl/core/bls_engine.sv
// Line engine of the stepper: line setup on load and one Bresenham step per step command.
// It depends on bls_pkg for opcodes, styles, step sign positions and the control struct.
`timescale 1ns / 1ps
`default_nettype none

module bls_engine #(
    parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire bls_pkg::style_t       style,
    input  wire logic                  item_valid,
    input  wire bls_pkg::opcode_t      item_opcode,
    input  wire logic [COORD_BITS-1:0] item_start_x,
    input  wire logic [COORD_BITS-1:0] item_start_y,
    input  wire logic [COORD_BITS-1:0] item_end_x,
    input  wire logic [COORD_BITS-1:0] item_end_y,
    input  wire logic                  slot_free,
    output bls_pkg::eng_ctrl_t         ctrl,
    output logic [COORD_BITS-1:0]      pix_x,
    output logic [COORD_BITS-1:0]      pix_y,
    output logic                       pix_visible,
    output logic                       pix_last
);

    localparam int ERR_BITS   = COORD_BITS + 3;
    localparam int STEPS_BITS = COORD_BITS + 1;

    logic [COORD_BITS-1:0]         cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0]         cur_y_reg, cur_y_next;
    logic signed [ERR_BITS-1:0]    error_term_reg, error_term_next;
    logic [COORD_BITS-1:0]         major_delta_reg, major_delta_next;
    logic [COORD_BITS-1:0]         minor_delta_reg, minor_delta_next;
    logic [bls_pkg::SIGN_BITS-1:0] step_signs_reg, step_signs_next;
    logic                          swap_axes_reg, swap_axes_next;
    logic [STEPS_BITS-1:0]         steps_left_reg, steps_left_next;
    bls_pkg::phase_t               pattern_phase_reg, pattern_phase_next;

    logic [COORD_BITS-1:0]         delta_x;
    logic [COORD_BITS-1:0]         delta_y;
    logic                          load_swap;
    logic [COORD_BITS-1:0]         load_major;
    logic [COORD_BITS-1:0]         load_minor;
    logic [bls_pkg::SIGN_BITS-1:0] load_signs;
    logic signed [ERR_BITS-1:0]    load_error;

    logic                          is_load;
    logic                          need_out;
    logic                          err_nonneg;
    logic                          move_x;
    logic                          move_y;
    logic [COORD_BITS-1:0]         step_x;
    logic [COORD_BITS-1:0]         step_y;
    logic signed [ERR_BITS-1:0]    twice_major;
    logic signed [ERR_BITS-1:0]    twice_minor;
    logic signed [ERR_BITS-1:0]    step_error;

    always_comb
    begin
        delta_x = (item_end_x >= item_start_x) ? (item_end_x - item_start_x)
                                               : (item_start_x - item_end_x);
        delta_y = (item_end_y >= item_start_y) ? (item_end_y - item_start_y)
                                               : (item_start_y - item_end_y);
        load_swap  = (delta_y > delta_x);
        load_major = load_swap ? delta_y : delta_x;
        load_minor = load_swap ? delta_x : delta_y;
        load_error = $signed({2'b00, load_minor, 1'b0}) - $signed({3'b000, load_major});

        load_signs = '0;
        load_signs[bls_pkg::SIGN_X_MOVE] = (item_end_x != item_start_x);
        load_signs[bls_pkg::SIGN_X_NEG]  = (item_end_x < item_start_x);
        load_signs[bls_pkg::SIGN_Y_MOVE] = (item_end_y != item_start_y);
        load_signs[bls_pkg::SIGN_Y_NEG]  = (item_end_y < item_start_y);
    end

    always_comb
    begin
        err_nonneg  = (error_term_reg >= 0);
        twice_major = $signed({2'b00, major_delta_reg, 1'b0});
        twice_minor = $signed({2'b00, minor_delta_reg, 1'b0});
        step_error  = error_term_reg + twice_minor - (err_nonneg ? twice_major : '0);

        move_x = step_signs_reg[bls_pkg::SIGN_X_MOVE] && (!swap_axes_reg || err_nonneg);
        move_y = step_signs_reg[bls_pkg::SIGN_Y_MOVE] && (swap_axes_reg || err_nonneg);

        if (!move_x)
        begin
            step_x = cur_x_reg;
        end
        else if (step_signs_reg[bls_pkg::SIGN_X_NEG])
        begin
            step_x = cur_x_reg - COORD_BITS'(1);
        end
        else
        begin
            step_x = cur_x_reg + COORD_BITS'(1);
        end

        if (!move_y)
        begin
            step_y = cur_y_reg;
        end
        else if (step_signs_reg[bls_pkg::SIGN_Y_NEG])
        begin
            step_y = cur_y_reg - COORD_BITS'(1);
        end
        else
        begin
            step_y = cur_y_reg + COORD_BITS'(1);
        end
    end

    always_comb
    begin
        is_load   = item_valid && (item_opcode == bls_pkg::OP_LOAD);
        need_out  = item_valid && (item_opcode == bls_pkg::OP_STEP) && (steps_left_reg != '0);
        ctrl.take = item_valid && (!need_out || slot_free);
        ctrl.emit = need_out && slot_free;
    end

    always_comb
    begin
        cur_x_next         = cur_x_reg;
        cur_y_next         = cur_y_reg;
        error_term_next    = error_term_reg;
        major_delta_next   = major_delta_reg;
        minor_delta_next   = minor_delta_reg;
        step_signs_next    = step_signs_reg;
        swap_axes_next     = swap_axes_reg;
        steps_left_next    = steps_left_reg;
        pattern_phase_next = pattern_phase_reg;

        if (is_load)
        begin
            cur_x_next         = item_start_x;
            cur_y_next         = item_start_y;
            error_term_next    = load_error;
            major_delta_next   = load_major;
            minor_delta_next   = load_minor;
            step_signs_next    = load_signs;
            swap_axes_next     = load_swap;
            steps_left_next    = {1'b0, load_major} + STEPS_BITS'(1);
            pattern_phase_next = '0;
        end
        else if (ctrl.emit)
        begin
            cur_x_next      = step_x;
            cur_y_next      = step_y;
            error_term_next = step_error;
            steps_left_next = steps_left_reg - STEPS_BITS'(1);
            if (pattern_phase_reg == bls_pkg::phase_t'(bls_pkg::PATTERN_LEN - 1))
            begin
                pattern_phase_next = '0;
            end
            else
            begin
                pattern_phase_next = pattern_phase_reg + bls_pkg::phase_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg         <= '0;
            cur_y_reg         <= '0;
            error_term_reg    <= '0;
            major_delta_reg   <= '0;
            minor_delta_reg   <= '0;
            step_signs_reg    <= '0;
            swap_axes_reg     <= 1'b0;
            steps_left_reg    <= '0;
            pattern_phase_reg <= '0;
        end
        else
        begin
            cur_x_reg         <= cur_x_next;
            cur_y_reg         <= cur_y_next;
            error_term_reg    <= error_term_next;
            major_delta_reg   <= major_delta_next;
            minor_delta_reg   <= minor_delta_next;
            step_signs_reg    <= step_signs_next;
            swap_axes_reg     <= swap_axes_next;
            steps_left_reg    <= steps_left_next;
            pattern_phase_reg <= pattern_phase_next;
        end
    end

    assign pix_x       = cur_x_reg;
    assign pix_y       = cur_y_reg;
    assign pix_visible = bls_pkg::style_draws(style, pattern_phase_reg);
    assign pix_last    = (steps_left_reg == STEPS_BITS'(1));

endmodule

`default_nettype wire

### rtl/core/bls_out_stage.sv
// Result register of the line stepper: holds one pixel until the receiver takes it.
// It depends on bls_pkg for the engine control struct.
`timescale 1ns / 1ps
`default_nettype none

module bls_out_stage #(
    parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire bls_pkg::eng_ctrl_t    ctrl,
    input  wire logic [COORD_BITS-1:0] pix_x,
    input  wire logic [COORD_BITS-1:0] pix_y,
    input  wire logic                  pix_visible,
    input  wire logic                  pix_last,
    output logic                       slot_free,
    output logic                       pixel_valid,
    input  wire logic                  pixel_ready,
    output logic [COORD_BITS-1:0]      pixel_x,
    output logic [COORD_BITS-1:0]      pixel_y,
    output logic                       visible,
    output logic                       last_pixel
);

    logic                  valid_reg;
    logic [COORD_BITS-1:0] x_reg;
    logic [COORD_BITS-1:0] y_reg;
    logic                  visible_reg;
    logic                  last_reg;

    assign slot_free = !valid_reg || pixel_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.emit)
        begin
            valid_reg <= 1'b1;
        end
        else if (pixel_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit)
        begin
            x_reg       <= pix_x;
            y_reg       <= pix_y;
            visible_reg <= pix_visible;
            last_reg    <= pix_last;
        end
    end

    assign pixel_valid = valid_reg;
    assign pixel_x     = x_reg;
    assign pixel_y     = y_reg;
    assign visible     = visible_reg;
    assign last_pixel  = last_reg;

endmodule

`default_nettype wire

### rtl/core/styled_bresenham_line_stepper.sv
// Top level of the styled Bresenham line stepper.
// It depends on bls_pkg, the channel interfaces, bls_in_stage, bls_engine and bls_out_stage.
//
// The cmd channel carries load and step commands. A load transfer sets up a line between
// two endpoints and gives no pixel. Each step transfer on an active line gives one pixel
// on the pixel channel, from the start point to the end point, with a visible bit from the
// line style and a last_pixel marker on the end point. A step with no active line gives
// nothing. A line of equal endpoints is a single pixel marked last.
// The cfg channel writes the line style; it is always ready. The user is bound to see that
// it is written only while idle; the block itself does not enforce this.
// A step waits in the command register; the engine then advances the line state and
// fills the pixel register, from which the pixel is transferred.
// Throughput: one command per cycle, unless a pending step waits for the pixel register.
// The next command is taken while a finished pixel waits, as long as the command in the
// command register gives no pixel or the waiting pixel is taken. When the receiver holds
// pixel.ready low, the pixel stays stable, a pending step waits there and cmd.ready falls.
// Reset clears the line state, so no line is active and the style is simple.
`timescale 1ns / 1ps
`default_nettype none

module styled_bresenham_line_stepper #(
    parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bls_cmd_if.sink    cmd,
    bls_pixel_if.source pixel,
    bls_cfg_if.sink    cfg
);

    bls_pkg::style_t       line_style_reg;
    bls_pkg::eng_ctrl_t    ctrl;
    logic                  slot_free;
    logic                  item_valid;
    bls_pkg::opcode_t      item_opcode;
    logic [COORD_BITS-1:0] item_start_x;
    logic [COORD_BITS-1:0] item_start_y;
    logic [COORD_BITS-1:0] item_end_x;
    logic [COORD_BITS-1:0] item_end_y;
    logic [COORD_BITS-1:0] pix_x;
    logic [COORD_BITS-1:0] pix_y;
    logic                  pix_visible;
    logic                  pix_last;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_style_reg <= bls_pkg::STYLE_SIMPLE;
        end
        else if (cfg.valid)
        begin
            line_style_reg <= cfg.line_style;
        end
    end

    bls_in_stage #(
        .COORD_BITS (COORD_BITS)
    ) u_in_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd.valid),
        .cmd_ready    (cmd.ready),
        .cmd_opcode   (cmd.opcode),
        .cmd_start_x  (cmd.start_x),
        .cmd_start_y  (cmd.start_y),
        .cmd_end_x    (cmd.end_x),
        .cmd_end_y    (cmd.end_y),
        .ctrl         (ctrl),
        .item_valid   (item_valid),
        .item_opcode  (item_opcode),
        .item_start_x (item_start_x),
        .item_start_y (item_start_y),
        .item_end_x   (item_end_x),
        .item_end_y   (item_end_y)
    );

    bls_engine #(
        .COORD_BITS (COORD_BITS)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .style        (line_style_reg),
        .item_valid   (item_valid),
        .item_opcode  (item_opcode),
        .item_start_x (item_start_x),
        .item_start_y (item_start_y),
        .item_end_x   (item_end_x),
        .item_end_y   (item_end_y),
        .slot_free    (slot_free),
        .ctrl         (ctrl),
        .pix_x        (pix_x),
        .pix_y        (pix_y),
        .pix_visible  (pix_visible),
        .pix_last     (pix_last)
    );

    bls_out_stage #(
        .COORD_BITS (COORD_BITS)
    ) u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .pix_x       (pix_x),
        .pix_y       (pix_y),
        .pix_visible (pix_visible),
        .pix_last    (pix_last),
        .slot_free   (slot_free),
        .pixel_valid (pixel.valid),
        .pixel_ready (pixel.ready),
        .pixel_x     (pixel.pixel_x),
        .pixel_y     (pixel.pixel_y),
        .visible     (pixel.visible),
        .last_pixel  (pixel.last_pixel)
    );

endmodule

`default_nettype wire

### rtl/core/bls_checker.sv
// Port-level checker of the line stepper, attached to the top level by a bind statement.
// It depends on bls_pkg and on the macros in assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bls_checker #(
    parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      cmd_ready,
    input wire logic                      pixel_valid,
    input wire logic                      pixel_ready,
    input wire logic [2*COORD_BITS+1:0]   pixel_payload
);

    logic pixel_stall;

    assign pixel_stall = pixel_valid && !pixel_ready;

    `BLS_ASSERT_NEXT(a_pixel_valid_holds, clk, rst_n, pixel_stall, pixel_valid)
    `BLS_ASSERT_NEXT(a_pixel_payload_holds, clk, rst_n, pixel_stall, $stable(pixel_payload))
    `BLS_ASSERT_SAME(a_cmd_ready_when_drained, clk, rst_n, pixel_ready, cmd_ready)

endmodule

bind styled_bresenham_line_stepper bls_checker #(
    .COORD_BITS (COORD_BITS)
) u_bls_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_ready     (cmd.ready),
    .pixel_valid   (pixel.valid),
    .pixel_ready   (pixel.ready),
    .pixel_payload ({pixel.pixel_x, pixel.pixel_y, pixel.visible, pixel.last_pixel})
);

`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench for the styled Bresenham line stepper.
// Depends on bls_pkg and the channel interfaces in bls_if.sv. It drives random and
// directed load and step commands and checks every pixel against its own line predictor.
`timescale 1ns / 1ps

module tb;

    localparam int XY_BITS = bls_pkg::COORD_BITS_DEF;
    localparam int XY_MAX = (1 << XY_BITS) - 1;
    localparam int ERR_BITS = XY_BITS + 3;
    localparam int QUIET_LIMIT = 1000;
    localparam int PHASE_ITEMS = 140;
    localparam int NUM_PHASES = 8;

    typedef logic [XY_BITS-1:0] coord_t;

    typedef struct {
        coord_t x;
        coord_t y;
        logic   vis;
        logic   last;
    } pixel_rec_t;

    class line_tracker;
        bls_pkg::style_t               style;
        coord_t                        cur_x;
        coord_t                        cur_y;
        coord_t                        major;
        coord_t                        minor;
        logic signed [ERR_BITS-1:0]    err;
        logic [bls_pkg::SIGN_BITS-1:0] dirs;
        logic                          swap;
        logic [XY_BITS:0]              steps_left;
        bls_pkg::phase_t               phase;
        pixel_rec_t                    pending_pixels[$];
        int                            errors;
        int                            commands;
        int                            loads;
        int                            idle_steps;
        int                            checked;
        int                            lines_ended;

        function new();
            style = bls_pkg::STYLE_SIMPLE;
            cur_x = '0;
            cur_y = '0;
            major = '0;
            minor = '0;
            err = '0;
            dirs = '0;
            swap = 1'b0;
            steps_left = '0;
            phase = '0;
            errors = 0;
            commands = 0;
            loads = 0;
            idle_steps = 0;
            checked = 0;
            lines_ended = 0;
        endfunction

        function int pending();
            return pending_pixels.size();
        endfunction

        function coord_t nudge(coord_t v, logic moves, logic neg);
            if (!moves)
            begin
                return v;
            end
            return neg ? coord_t'(v - 1'b1) : coord_t'(v + 1'b1);
        endfunction

        function logic pattern_on();
            case (style)
                bls_pkg::STYLE_DOTTED:
                begin
                    return phase[0] == 1'b0;
                end
                bls_pkg::STYLE_DASHED:
                begin
                    return int'(phase) < bls_pkg::DASH_ON;
                end
                default:
                begin
                    return 1'b1;
                end
            endcase
        endfunction

        function void note_command(bls_pkg::opcode_t op, coord_t sx, coord_t sy, coord_t ex,
                                   coord_t ey);
            pixel_rec_t p;
            coord_t     dx;
            coord_t     dy;
            commands++;
            if (op == bls_pkg::OP_LOAD)
            begin
                loads++;
                dx = (ex >= sx) ? coord_t'(ex - sx) : coord_t'(sx - ex);
                dy = (ey >= sy) ? coord_t'(ey - sy) : coord_t'(sy - ey);
                dirs = '0;
                dirs[bls_pkg::SIGN_X_MOVE] = (ex != sx);
                dirs[bls_pkg::SIGN_X_NEG] = (ex < sx);
                dirs[bls_pkg::SIGN_Y_MOVE] = (ey != sy);
                dirs[bls_pkg::SIGN_Y_NEG] = (ey < sy);
                swap = (dy > dx);
                major = swap ? dy : dx;
                minor = swap ? dx : dy;
                err = ERR_BITS'(2 * int'(minor) - int'(major));
                cur_x = sx;
                cur_y = sy;
                steps_left = {1'b0, major} + 1'b1;
                phase = '0;
                return;
            end
            if (steps_left == 0)
            begin
                idle_steps++;
                return;
            end
            p.x = cur_x;
            p.y = cur_y;
            p.vis = pattern_on();
            p.last = (steps_left == 1);
            pending_pixels.push_back(p);
            if (err >= 0)
            begin
                if (swap)
                begin
                    cur_x = nudge(cur_x, dirs[bls_pkg::SIGN_X_MOVE], dirs[bls_pkg::SIGN_X_NEG]);
                end
                else
                begin
                    cur_y = nudge(cur_y, dirs[bls_pkg::SIGN_Y_MOVE], dirs[bls_pkg::SIGN_Y_NEG]);
                end
                err = ERR_BITS'(int'(err) - 2 * int'(major));
            end
            if (swap)
            begin
                cur_y = nudge(cur_y, dirs[bls_pkg::SIGN_Y_MOVE], dirs[bls_pkg::SIGN_Y_NEG]);
            end
            else
            begin
                cur_x = nudge(cur_x, dirs[bls_pkg::SIGN_X_MOVE], dirs[bls_pkg::SIGN_X_NEG]);
            end
            err = ERR_BITS'(int'(err) + 2 * int'(minor));
            phase = bls_pkg::phase_t'(phase + 1'b1);
            steps_left = steps_left - 1'b1;
        endfunction

        function void check_pixel(coord_t x, coord_t y, logic vis, logic last);
            pixel_rec_t want;
            if (pending_pixels.size() == 0)
            begin
                $display("%0t: unexpected pixel: expected none, actual (%0d,%0d) vis %0b last %0b",
                         $time, x, y, vis, last);
                errors++;
                return;
            end
            want = pending_pixels.pop_front();
            checked++;
            if (want.last)
            begin
                lines_ended++;
            end
            if (x !== want.x)
            begin
                $display("%0t: pixel_x mismatch: expected %0d, actual %0d", $time, want.x, x);
                errors++;
            end
            if (y !== want.y)
            begin
                $display("%0t: pixel_y mismatch: expected %0d, actual %0d", $time, want.y, y);
                errors++;
            end
            if (vis !== want.vis)
            begin
                $display("%0t: visible mismatch: expected %0b, actual %0b", $time, want.vis, vis);
                errors++;
            end
            if (last !== want.last)
            begin
                $display("%0t: last_pixel mismatch: expected %0b, actual %0b",
                         $time, want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    bls_cmd_if   cmd_ch();
    bls_pixel_if pix_ch();
    bls_cfg_if   cfg_ch();

    line_tracker tracker;
    int          cmd_run = 0;
    int          pix_run = 0;
    int          pix_wait = 0;
    int          quiet_cycles = 0;
    int          style_writes = 0;

    styled_bresenham_line_stepper dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .pixel (pix_ch),
        .cfg   (cfg_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Mostly a random wait, with occasional runs of back-to-back transfers.
    function automatic int draw_wait(inout int run_len);
        if (run_len > 0)
        begin
            run_len--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            run_len = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 7);
    endfunction

    function automatic coord_t pick_coord();
        case ($urandom_range(0, 19))
            0:
            begin
                return '0;
            end
            1:
            begin
                return coord_t'(XY_MAX);
            end
            default:
            begin
                return coord_t'($urandom_range(0, XY_MAX));
            end
        endcase
    endfunction

    function automatic coord_t shift_coord(coord_t c, int d);
        int r;
        r = $urandom_range(0, 1) ? int'(c) + d : int'(c) - d;
        if (r < 0)
        begin
            r = 0;
        end
        if (r > XY_MAX)
        begin
            r = XY_MAX;
        end
        return coord_t'(r);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pix_ch.valid && pix_ch.ready)
            begin
                tracker.check_pixel(pix_ch.pixel_x, pix_ch.pixel_y, pix_ch.visible,
                                    pix_ch.last_pixel);
                pix_wait = draw_wait(pix_run);
            end
            if (pix_wait > 0)
            begin
                pix_ch.ready <= 1'b0;
                pix_wait--;
            end
            else
            begin
                pix_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_ch.valid && cmd_ch.ready) || (pix_ch.valid && pix_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles, %0d pixels still expected",
                         $time, QUIET_LIMIT, tracker.pending());
                $display("[styled_bresenham_line_stepper] ERROR");
                $finish;
            end
        end
    end

    task automatic send_cmd(bls_pkg::opcode_t op, coord_t sx, coord_t sy, coord_t ex,
                            coord_t ey);
        int gap;
        gap = draw_wait(cmd_run);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.opcode <= op;
        cmd_ch.start_x <= sx;
        cmd_ch.start_y <= sy;
        cmd_ch.end_x <= ex;
        cmd_ch.end_y <= ey;
        @(posedge clk);
        while (!cmd_ch.ready)
        begin
            @(posedge clk);
        end
        tracker.note_command(op, sx, sy, ex, ey);
    endtask

    task automatic send_step();
        send_cmd(bls_pkg::OP_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                 coord_t'($urandom));
    endtask

    task automatic send_steps(int n);
        repeat (n) send_step();
    endtask

    task automatic write_style(bls_pkg::style_t s);
        cfg_ch.line_style <= s;
        cfg_ch.valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        tracker.style = s;
        cfg_ch.valid <= 1'b0;
        style_writes++;
    endtask

    task automatic settle();
        cmd_ch.valid <= 1'b0;
        while (tracker.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Mostly complete lines of random shape, some cut short or stepped past their end,
    // and a little noise of stray loads and steps.
    task automatic run_random(int budget);
        int     sent;
        int     span;
        int     adx;
        int     ady;
        int     n;
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
        sent = 0;
        while (sent < budget)
        begin
            if ($urandom_range(0, 99) < 8)
            begin
                if ($urandom_range(0, 1))
                begin
                    send_step();
                end
                else
                begin
                    send_cmd(bls_pkg::OP_LOAD, pick_coord(), pick_coord(), pick_coord(),
                             pick_coord());
                end
                sent++;
            end
            else
            begin
                n = $urandom_range(0, 99);
                span = (n < 80) ? 12 : ((n < 95) ? 120 : XY_MAX);
                sx = pick_coord();
                sy = pick_coord();
                ex = shift_coord(sx, $urandom_range(0, span));
                ey = shift_coord(sy, $urandom_range(0, span));
                send_cmd(bls_pkg::OP_LOAD, sx, sy, ex, ey);
                sent++;
                adx = (ex >= sx) ? int'(ex) - int'(sx) : int'(sx) - int'(ex);
                ady = (ey >= sy) ? int'(ey) - int'(sy) : int'(sy) - int'(ey);
                n = ((adx > ady) ? adx : ady) + 1;
                if (n > 160)
                begin
                    n = $urandom_range(16, 160);
                end
                else if ($urandom_range(0, 9) == 0)
                begin
                    n = $urandom_range(0, n);
                end
                else if ($urandom_range(0, 4) == 0)
                begin
                    n += $urandom_range(1, 2);
                end
                send_steps(n);
                sent += n;
            end
        end
    endtask

    initial
    begin
        bls_pkg::style_t plan [NUM_PHASES];
        rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.opcode = bls_pkg::OP_LOAD;
        cmd_ch.start_x = '0;
        cmd_ch.start_y = '0;
        cmd_ch.end_x = '0;
        cmd_ch.end_y = '0;
        pix_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.line_style = bls_pkg::STYLE_SIMPLE;
        tracker = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lines run under the reset style.
        send_step();
        send_cmd(bls_pkg::OP_LOAD, 11'd7, 11'd9, 11'd7, 11'd9);
        send_steps(2);
        send_cmd(bls_pkg::OP_LOAD, '0, '0, coord_t'(XY_MAX), coord_t'(XY_MAX));
        send_steps(3);
        send_cmd(bls_pkg::OP_LOAD, coord_t'(XY_MAX), coord_t'(XY_MAX), '0, '0);
        send_steps(2);
        send_cmd(bls_pkg::OP_LOAD, 11'd100, 11'd200, 11'd103, 11'd190);
        send_steps(3);
        send_cmd(bls_pkg::OP_LOAD, 11'd50, 11'd60, 11'd40, 11'd63);
        send_steps(2);
        send_cmd(bls_pkg::OP_LOAD, '0, coord_t'(XY_MAX), coord_t'(XY_MAX), coord_t'(XY_MAX));
        send_step();
        send_cmd(bls_pkg::OP_LOAD, coord_t'(XY_MAX), '0, coord_t'(XY_MAX), 11'd3);
        send_steps(4);
        settle();

        plan[0] = bls_pkg::STYLE_SOLID;
        plan[1] = bls_pkg::STYLE_DOTTED;
        plan[2] = bls_pkg::STYLE_DASHED;
        plan[3] = bls_pkg::STYLE_SIMPLE;
        for (int i = 4; i < NUM_PHASES; i++)
        begin
            plan[i] = bls_pkg::style_t'($urandom_range(0, 3));
        end
        for (int i = 0; i < NUM_PHASES; i++)
        begin
            write_style(plan[i]);
            run_random(PHASE_ITEMS);
            settle();
        end
        repeat (8) @(posedge clk);

        $display("Run covered %0d commands: %0d loads, %0d steps with no active line,",
                 tracker.commands, tracker.loads, tracker.idle_steps);
        $display("%0d style writes, and %0d pixels checked over %0d completed lines.",
                 style_writes, tracker.checked, tracker.lines_ended);
        if (tracker.errors == 0 && tracker.pending() == 0)
        begin
            $display("[styled_bresenham_line_stepper] OK");
        end
        else
        begin
            $display("[styled_bresenham_line_stepper] ERROR");
        end
        $finish;
    end

endmodule
